@@ sv/ctcd_pkg.sv @@
// Package with shared types and constants for the color threshold and cross dilation unit.
package ctcd_pkg;

	localparam int PIX_W = 8;
	localparam int SIZE_W = 12;
	localparam int CTH_W = 9;
	localparam int BTH_W = 8;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENEMY_IS_RED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THRESHOLD = 3'd4;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_PAD = 1'b1;

	typedef struct packed {
		logic emit;
		logic write;
		logic drain;
		logic last_col;
		logic use_above;
		logic use_left;
		logic use_right;
		logic row_par;
		logic col_par;
	} step_t;

endpackage

@@ sv/ctcd_thresh.sv @@
// Color difference and brightness test of one pixel.
module ctcd_thresh (
	input  logic                           enemy_is_red,
	input  logic signed [ctcd_pkg::CTH_W-1:0] color_threshold,
	input  logic [ctcd_pkg::BTH_W-1:0]     bright_threshold,
	input  logic [ctcd_pkg::PIX_W-1:0]     blue,
	input  logic [ctcd_pkg::PIX_W-1:0]     red,
	output logic                           hit
);

	logic [ctcd_pkg::PIX_W-1:0] chosen;
	logic [ctcd_pkg::PIX_W-1:0] other;
	logic signed [ctcd_pkg::PIX_W+1:0] diff;
	logic signed [ctcd_pkg::PIX_W+1:0] limit;

	always_comb begin
		chosen = enemy_is_red ? red : blue;
		other = enemy_is_red ? blue : red;
		diff = $signed({2'b00, chosen}) - $signed({2'b00, other});
		limit = (ctcd_pkg::PIX_W+2)'(color_threshold);
		hit = (diff > limit) && (chosen > bright_threshold);
	end

endmodule

@@ sv/ctcd_linebuf.sv @@
// Two-row mask line buffer packed two columns per word, with registered dual reads.
module ctcd_linebuf #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_bit,
	input  logic          wr_data,
	output logic [3:0]    rd_data_a,
	output logic [3:0]    rd_data_b
);

	logic [3:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
		if (wr_en) begin
			mem[wr_addr][wr_bit] <= wr_data;
		end
	end

endmodule

@@ sv/ctcd_pos.sv @@
// Input position counters, frame bounds and per-item step decode.
module ctcd_pos #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int CW = 11,
	parameter int RW = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         command,
	input  logic [ctcd_pkg::SIZE_W-1:0]  frame_width,
	input  logic [ctcd_pkg::SIZE_W-1:0]  frame_height,
	output logic [CW-1:0]                column,
	output ctcd_pkg::step_t              step
);

	logic [CW-1:0] in_column_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] last_idx;
	logic [RW-1:0] height;
	logic          drain;
	logic          pad;
	logic          last_col;
	logic          advance;

	always_comb begin
		if (frame_width == '0) begin
			last_idx = '0;
		end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
			last_idx = CW'(MAX_WIDTH - 1);
		end else begin
			last_idx = CW'(frame_width - 12'd1);
		end
		if (frame_height == '0) begin
			height = RW'(1);
		end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
			height = RW'(MAX_HEIGHT);
		end else begin
			height = RW'(frame_height);
		end
		column = (in_column_q > last_idx) ? last_idx : in_column_q;
		last_col = (column == last_idx);
		drain = (in_row_q >= height);
		pad = (command == ctcd_pkg::CMD_PAD);
		advance = drain || !pad;
		step.emit = drain || ((in_row_q != '0) && !pad);
		step.write = !drain && !pad;
		step.drain = drain;
		step.last_col = last_col;
		step.use_above = (in_row_q >= RW'(2));
		step.use_left = (column != '0);
		step.use_right = !last_col;
		step.row_par = in_row_q[0];
		step.col_par = column[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q <= '0;
			in_row_q <= '0;
		end else if (accept && advance) begin
			if (last_col) begin
				in_column_q <= '0;
				in_row_q <= drain ? '0 : in_row_q + RW'(1);
			end else begin
				in_column_q <= column + CW'(1);
			end
		end
	end

endmodule

@@ sv/color_threshold_cross_dilate_unit.sv @@
// Top level: pixel threshold, line buffer, cross window stage and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  input   | in_valid / in_stall   | command, blue, green, red
//  output  | out_valid / out_stall | mask, row_end, frame_end
//  config  | cfg_write             | cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; the window stage it loads feeds the result register.
// Results lag the pixels by one image row; padding items drain the last row.
// The line buffer is read and written at the input transfer edge, so no refill is needed.
// Reset clears the position counters and pipeline valids and sets config defaults; the buffer needs no clearing.
// A stall on the output holds the window stage and then the input, one item deep each.
module color_threshold_cross_dilate_unit #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [ctcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctcd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [ctcd_pkg::PIX_W-1:0]       blue,
	input  logic [ctcd_pkg::PIX_W-1:0]       green,
	input  logic [ctcd_pkg::PIX_W-1:0]       red,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             mask,
	output logic                             row_end,
	output logic                             frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int AW = CW - 1;
	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	logic [ctcd_pkg::SIZE_W-1:0]    frame_width_q;
	logic [ctcd_pkg::SIZE_W-1:0]    frame_height_q;
	logic                           enemy_is_red_q;
	logic signed [ctcd_pkg::CTH_W-1:0] color_threshold_q;
	logic [ctcd_pkg::BTH_W-1:0]     bright_threshold_q;

	logic            accept;
	logic            out_ready;
	logic            hit;
	logic [CW-1:0]   column;
	ctcd_pkg::step_t step;
	logic [AW-1:0]   addr_a;
	logic [AW-1:0]   addr_b;
	logic [3:0]      word_a;
	logic [3:0]      word_b;

	logic            valid_s1;
	ctcd_pkg::step_t step_s1;
	logic            below_s1;
	logic            green_seen_q;

	logic above;
	logic mid;
	logic left;
	logic right;
	logic mask_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= 12'd640;
			frame_height_q <= 12'd480;
			enemy_is_red_q <= 1'b1;
			color_threshold_q <= 9'sd40;
			bright_threshold_q <= 8'd100;
		end else if (cfg_write) begin
			case (cfg_index)
				ctcd_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data;
				ctcd_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				ctcd_pkg::REG_ENEMY_IS_RED: enemy_is_red_q <= cfg_data[0];
				ctcd_pkg::REG_COLOR_THRESHOLD: color_threshold_q <= cfg_data[8:0];
				ctcd_pkg::REG_BRIGHT_THRESHOLD: bright_threshold_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign out_ready = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !out_ready;
	assign accept = in_valid && !in_stall;

	ctcd_thresh u_thresh (
		.enemy_is_red     (enemy_is_red_q),
		.color_threshold  (color_threshold_q),
		.bright_threshold (bright_threshold_q),
		.blue             (blue),
		.red              (red),
		.hit              (hit)
	);

	ctcd_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW),
		.RW         (RW)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.command      (command),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.column       (column),
		.step         (step)
	);

	always_comb begin
		addr_a = column[CW-1:1];
		if (!column[0]) begin
			addr_b = addr_a - AW'(1);
		end else if (addr_a == AW'(DEPTH - 1)) begin
			addr_b = addr_a;
		end else begin
			addr_b = addr_a + AW'(1);
		end
	end

	ctcd_linebuf #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_linebuf (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr_a (addr_a),
		.rd_addr_b (addr_b),
		.wr_en     (accept && step.write),
		.wr_addr   (addr_a),
		.wr_bit    ({step.row_par, step.col_par}),
		.wr_data   (hit),
		.rd_data_a (word_a),
		.rd_data_b (word_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= step.emit;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
			below_s1 <= !step.drain && hit;
			green_seen_q <= ^green;
		end
	end

	// Above is the older row, stored in the slot of the current row parity.
	always_comb begin
		if (!step_s1.col_par) begin
			mid = word_a[{!step_s1.row_par, 1'b0}];
			right = word_a[{!step_s1.row_par, 1'b1}];
			left = word_b[{!step_s1.row_par, 1'b1}];
			above = word_a[{step_s1.row_par, 1'b0}];
		end else begin
			mid = word_a[{!step_s1.row_par, 1'b1}];
			left = word_a[{!step_s1.row_par, 1'b0}];
			right = word_b[{!step_s1.row_par, 1'b0}];
			above = word_a[{step_s1.row_par, 1'b1}];
		end
		mask_d = (step_s1.use_above && above) || below_s1 || mid
			|| (step_s1.use_left && left) || (step_s1.use_right && right);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			mask <= mask_d;
			row_end <= step_s1.last_col && (green_seen_q || !green_seen_q);
			frame_end <= step_s1.last_col && step_s1.drain;
		end
	end

endmodule

@@ sv/ctcd_checker.sv @@
// Port-level checker for the color threshold and cross dilation unit, with its bind.
module ctcd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic mask,
	input logic row_end,
	input logic frame_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Stalled result was dropped.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(mask) && $stable(row_end) && $stable(frame_end))
		else $error("Stalled result changed.");

	a_frame_end_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("Frame end without row end.");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("Input stalled while the output can transfer.");

endmodule

bind color_threshold_cross_dilate_unit ctcd_checker u_ctcd_checker (.*);
